[src/y86x_pkg.sv]
// Shared types, encodings and helper functions for the Y86-64 execute stage.
// Used by y86x_alu, y86x_cond and y86_execute_stage_top; depends on nothing.
package y86x_pkg;

   localparam int WORD_BITS = 64;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [3:0]           icode_type;
   typedef logic [3:0]           ifun_type;
   typedef logic [2:0]           stat_type;
   typedef logic [3:0]           reg_id_type;

   // Instruction codes.
   localparam icode_type ICODE_HALT   = 4'd0;
   localparam icode_type ICODE_NOP    = 4'd1;
   localparam icode_type ICODE_RRMOV  = 4'd2;
   localparam icode_type ICODE_IRMOV  = 4'd3;
   localparam icode_type ICODE_RMMOV  = 4'd4;
   localparam icode_type ICODE_MRMOV  = 4'd5;
   localparam icode_type ICODE_OP     = 4'd6;
   localparam icode_type ICODE_JXX    = 4'd7;
   localparam icode_type ICODE_CALL   = 4'd8;
   localparam icode_type ICODE_RET    = 4'd9;
   localparam icode_type ICODE_PUSH   = 4'd10;
   localparam icode_type ICODE_POP    = 4'd11;

   // ALU functions.
   localparam ifun_type ALU_ADD = 4'd0;
   localparam ifun_type ALU_SUB = 4'd1;
   localparam ifun_type ALU_AND = 4'd2;
   localparam ifun_type ALU_XOR = 4'd3;

   // Jump and move conditions.
   localparam ifun_type COND_ALWAYS = 4'd0;
   localparam ifun_type COND_LE     = 4'd1;
   localparam ifun_type COND_L      = 4'd2;
   localparam ifun_type COND_E      = 4'd3;
   localparam ifun_type COND_NE     = 4'd4;
   localparam ifun_type COND_GE     = 4'd5;
   localparam ifun_type COND_G      = 4'd6;

   // Status codes.
   localparam stat_type STAT_AOK = 3'd1;
   localparam stat_type STAT_HLT = 3'd2;
   localparam stat_type STAT_ADR = 3'd3;
   localparam stat_type STAT_INS = 3'd4;

   localparam reg_id_type REG_NONE = 4'hF;

   // Stack pointer adjustments.
   localparam word_type STACK_DOWN = ~word_type'(7);
   localparam word_type STACK_UP   = word_type'(8);

   typedef struct packed {
      logic of_flag;
      logic sf_flag;
      logic zf_flag;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{of_flag: 1'b0, sf_flag: 1'b0, zf_flag: 1'b1};

   typedef struct packed {
      word_type  val_e;
      logic      set_cc;
      flags_type flags;
   } alu_out_type;

   function automatic logic is_exception(input stat_type s);
      return (s == STAT_HLT) || (s == STAT_ADR) || (s == STAT_INS);
   endfunction

endpackage

[src/y86x_alu.sv]
// Operand selection, ALU and new condition flags of the execute stage.
// Depends on y86x_pkg.
module y86x_alu (
   input  y86x_pkg::icode_type   icode,
   input  y86x_pkg::ifun_type    ifun,
   input  y86x_pkg::word_type    val_a,
   input  y86x_pkg::word_type    val_b,
   input  y86x_pkg::word_type    val_c,
   output y86x_pkg::alu_out_type alu_out
);
   import y86x_pkg::*;

   word_type alu_a;
   word_type alu_b;
   word_type result;
   ifun_type fun;
   logic     fun_ok;
   logic     ovf;
   logic     sign_a;
   logic     sign_b;
   logic     sign_e;

   always_comb begin
      unique case (icode)
         ICODE_RRMOV, ICODE_OP:                  alu_a = val_a;
         ICODE_IRMOV, ICODE_RMMOV, ICODE_MRMOV:  alu_a = val_c;
         ICODE_CALL, ICODE_PUSH:                 alu_a = STACK_DOWN;
         ICODE_RET, ICODE_POP:                   alu_a = STACK_UP;
         default:                                alu_a = '0;
      endcase
   end

   always_comb begin
      unique case (icode)
         ICODE_RMMOV, ICODE_MRMOV, ICODE_OP, ICODE_CALL,
         ICODE_RET, ICODE_PUSH, ICODE_POP:       alu_b = val_b;
         default:                                alu_b = '0;
      endcase
   end

   // Everything except an OPq instruction uses the adder.
   assign fun = (icode == ICODE_OP) ? ifun : ALU_ADD;

   always_comb begin
      fun_ok = 1'b1;
      unique case (fun)
         ALU_ADD: result = alu_a + alu_b;
         ALU_SUB: result = alu_b - alu_a;
         ALU_AND: result = alu_a & alu_b;
         ALU_XOR: result = alu_a ^ alu_b;
         default: begin
            result = '0;
            fun_ok = 1'b0;
         end
      endcase
   end

   assign sign_a = alu_a[WORD_BITS-1];
   assign sign_b = alu_b[WORD_BITS-1];
   assign sign_e = result[WORD_BITS-1];

   always_comb begin
      unique case (fun)
         ALU_ADD: ovf = (sign_a == sign_b) && (sign_e != sign_a);
         ALU_SUB: ovf = (sign_b != sign_a) && (sign_e != sign_b);
         default: ovf = 1'b0;
      endcase
   end

   assign alu_out.val_e         = result;
   assign alu_out.set_cc        = (icode == ICODE_OP) && fun_ok;
   assign alu_out.flags.of_flag = ovf;
   assign alu_out.flags.sf_flag = sign_e;
   assign alu_out.flags.zf_flag = (result == '0);

endmodule

[src/y86x_cond.sv]
// Jump and conditional move condition evaluation from the kept flags.
// Depends on y86x_pkg.
module y86x_cond (
   input  y86x_pkg::icode_type icode,
   input  y86x_pkg::ifun_type  ifun,
   input  y86x_pkg::flags_type flags,
   output logic                cnd
);
   import y86x_pkg::*;

   logic lt;
   logic raw;

   assign lt = flags.sf_flag ^ flags.of_flag;

   always_comb begin
      unique case (ifun)
         COND_ALWAYS: raw = 1'b1;
         COND_LE:     raw = lt | flags.zf_flag;
         COND_L:      raw = lt;
         COND_E:      raw = flags.zf_flag;
         COND_NE:     raw = ~flags.zf_flag;
         COND_GE:     raw = ~lt;
         COND_G:      raw = ~lt & ~flags.zf_flag;
         default:     raw = 1'b0;
      endcase
   end

   assign cnd = raw && ((icode == ICODE_RRMOV) || (icode == ICODE_JXX));

endmodule

[src/y86_execute_stage_top.sv]
// Y86-64 execute stage: input register, one pass of ALU and condition logic, result register.
// An accepted item moves from the input register into the result register and is offered from there;
// one item can be accepted per cycle while the output is not stalled.
// The condition flags update as an OPq item moves into the result register, unless a later stage holds an exception.
// Synchronous active-high reset empties both registers and sets the flags to ZF=1, SF=0, OF=0.
// Depends on y86x_pkg, y86x_alu and y86x_cond.
module y86_execute_stage_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic [3:0]  req_function_code,
   input  logic [2:0]  req_status_in,
   input  logic [63:0] req_constant_value,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   input  logic [3:0]  req_dest_e_in,
   input  logic [3:0]  req_dest_m_in,
   input  logic [2:0]  req_memory_status,
   input  logic [2:0]  req_writeback_status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status_out,
   output logic [3:0]  rsp_command_out,
   output logic        rsp_condition_met,
   output logic [63:0] rsp_alu_result,
   output logic [63:0] rsp_operand_a_out,
   output logic [3:0]  rsp_dest_e_out,
   output logic [3:0]  rsp_dest_m_out,
   output logic        rsp_bubble
);
   import y86x_pkg::*;

   // Input register.
   logic       s1_valid_ff;
   icode_type  icode_ff;
   ifun_type   ifun_ff;
   stat_type   stat_ff;
   word_type   val_c_ff;
   word_type   val_a_ff;
   word_type   val_b_ff;
   reg_id_type dst_e_ff;
   reg_id_type dst_m_ff;
   logic       halt_later_ff;

   flags_type  flags_ff;
   flags_type  flags_in;

   // Result register.
   logic       rsp_valid_ff;
   stat_type   out_stat_ff;
   icode_type  out_icode_ff;
   logic       out_cnd_ff;
   word_type   out_val_e_ff;
   word_type   out_val_a_ff;
   reg_id_type out_dst_e_ff;
   reg_id_type out_dst_m_ff;
   logic       out_bubble_ff;

   alu_out_type alu_out;
   logic        cnd;
   logic        s2_adv;
   logic        s1_load;
   logic        s1_move;
   logic        flag_we;
   reg_id_type  dst_e_sel;

   assign s2_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_adv;
   assign s1_load   = req_valid && !req_stall;
   assign s1_move   = s1_valid_ff && s2_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load || s2_adv) begin
         s1_valid_ff <= s1_load;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         icode_ff      <= req_command;
         ifun_ff       <= req_function_code;
         stat_ff       <= req_status_in;
         val_c_ff      <= req_constant_value[WORD_BITS-1:0];
         val_a_ff      <= req_operand_a[WORD_BITS-1:0];
         val_b_ff      <= req_operand_b[WORD_BITS-1:0];
         dst_e_ff      <= req_dest_e_in;
         dst_m_ff      <= req_dest_m_in;
         halt_later_ff <= is_exception(req_memory_status) ||
                          is_exception(req_writeback_status);
      end
   end

   y86x_alu u_alu (
      .icode   (icode_ff),
      .ifun    (ifun_ff),
      .val_a   (val_a_ff),
      .val_b   (val_b_ff),
      .val_c   (val_c_ff),
      .alu_out (alu_out)
   );

   y86x_cond u_cond (
      .icode (icode_ff),
      .ifun  (ifun_ff),
      .flags (flags_ff),
      .cnd   (cnd)
   );

   // Flags are not touched while a later stage holds an exception.
   assign flag_we  = s1_move && alu_out.set_cc && !halt_later_ff;
   assign flags_in = flag_we ? alu_out.flags : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign dst_e_sel = ((icode_ff == ICODE_RRMOV) && !cnd) ? REG_NONE : dst_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         if (halt_later_ff) begin
            out_stat_ff   <= STAT_AOK;
            out_icode_ff  <= ICODE_NOP;
            out_cnd_ff    <= 1'b0;
            out_val_e_ff  <= '0;
            out_val_a_ff  <= '0;
            out_dst_e_ff  <= REG_NONE;
            out_dst_m_ff  <= REG_NONE;
            out_bubble_ff <= 1'b1;
         end else begin
            out_stat_ff   <= stat_ff;
            out_icode_ff  <= icode_ff;
            out_cnd_ff    <= cnd;
            out_val_e_ff  <= alu_out.val_e;
            out_val_a_ff  <= val_a_ff;
            out_dst_e_ff  <= dst_e_sel;
            out_dst_m_ff  <= dst_m_ff;
            out_bubble_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status_out    = out_stat_ff;
   assign rsp_command_out   = out_icode_ff;
   assign rsp_condition_met = out_cnd_ff;
   assign rsp_alu_result    = 64'(out_val_e_ff);
   assign rsp_operand_a_out = 64'(out_val_a_ff);
   assign rsp_dest_e_out    = out_dst_e_ff;
   assign rsp_dest_m_out    = out_dst_m_ff;
   assign rsp_bubble        = out_bubble_ff;

   a_stall_needs_item : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty input register");

   a_flags_only_on_op : assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(flags_ff)) |-> $past(flag_we))
      else $error("condition flags changed without an OPq item");

   a_bubble_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bubble) |->
         (rsp_command_out == ICODE_NOP) && (rsp_dest_e_out == REG_NONE) &&
         (rsp_dest_m_out == REG_NONE) && !rsp_condition_met)
      else $error("bubbled result is not a nop");

   a_cmov_cancel : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bubble && (rsp_command_out == ICODE_RRMOV) &&
       !rsp_condition_met) |-> (rsp_dest_e_out == REG_NONE))
      else $error("failed conditional move kept its destination");

   a_cond_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_condition_met) |->
         ((rsp_command_out == ICODE_RRMOV) || (rsp_command_out == ICODE_JXX)))
      else $error("condition set for an item that is neither jump nor move");

endmodule
